/* rtl/sct_pkg.sv */
// Package for the shell command tokenizer: token and mode codes, character
// constants and the per-byte lexer step function.
// No dependencies.
`timescale 1ns / 1ps

package sct_pkg;

	// Token kinds on the result channel.
	localparam logic [3:0] K_CHAR    = 4'd0;
	localparam logic [3:0] K_WEND    = 4'd1;
	localparam logic [3:0] K_LPAREN  = 4'd2;
	localparam logic [3:0] K_RPAREN  = 4'd3;
	localparam logic [3:0] K_AMP     = 4'd4;
	localparam logic [3:0] K_AND     = 4'd5;
	localparam logic [3:0] K_PIPE    = 4'd6;
	localparam logic [3:0] K_OR      = 4'd7;
	localparam logic [3:0] K_SEMI    = 4'd8;
	localparam logic [3:0] K_LESS    = 4'd9;
	localparam logic [3:0] K_GREATER = 4'd10;
	localparam logic [3:0] K_APPEND  = 4'd11;
	localparam logic [3:0] K_END     = 4'd12;

	// Lexer modes. Codes above M_COMMENT behave as general mode.
	localparam logic [3:0] M_GEN     = 4'd0;
	localparam logic [3:0] M_WORD    = 4'd1;
	localparam logic [3:0] M_SQ      = 4'd2;
	localparam logic [3:0] M_DQ      = 4'd3;
	localparam logic [3:0] M_ESCW    = 4'd4;
	localparam logic [3:0] M_ESCQ    = 4'd5;
	localparam logic [3:0] M_AMP     = 4'd6;
	localparam logic [3:0] M_BAR     = 4'd7;
	localparam logic [3:0] M_SEMI    = 4'd8;
	localparam logic [3:0] M_LESS    = 4'd9;
	localparam logic [3:0] M_GT      = 4'd10;
	localparam logic [3:0] M_COMMENT = 4'd11;

	// Character constants.
	localparam logic [7:0] C_NUL    = 8'h00;
	localparam logic [7:0] C_TAB    = 8'h09;
	localparam logic [7:0] C_LF     = 8'h0A;
	localparam logic [7:0] C_CR     = 8'h0D;
	localparam logic [7:0] C_SPACE  = 8'h20;
	localparam logic [7:0] C_DQUOTE = 8'h22;
	localparam logic [7:0] C_HASH   = 8'h23;
	localparam logic [7:0] C_AMP    = 8'h26;
	localparam logic [7:0] C_SQUOTE = 8'h27;
	localparam logic [7:0] C_LPAREN = 8'h28;
	localparam logic [7:0] C_RPAREN = 8'h29;
	localparam logic [7:0] C_SEMI   = 8'h3B;
	localparam logic [7:0] C_LESS   = 8'h3C;
	localparam logic [7:0] C_GT     = 8'h3E;
	localparam logic [7:0] C_BSLASH = 8'h5C;
	localparam logic [7:0] C_BAR    = 8'h7C;

	// One emitted token.
	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] ch;
	} tok_t;

	// Outcome of general-mode handling of one byte.
	typedef struct packed {
		logic [3:0] mode;
		logic       wne;
		logic       tok_v;
		tok_t       tok;
	} gen_res_t;

	// Outcome of one lexer step: next state and up to two tokens in order.
	typedef struct packed {
		logic [3:0] mode;
		logic       wne;
		logic [1:0] cnt;
		tok_t       r0;
		tok_t       r1;
	} step_res_t;

	function automatic logic is_delim(input logic [7:0] c);
		return c inside {C_NUL, C_SPACE, C_TAB, C_CR, C_LF, C_AMP, C_BAR, C_SEMI,
			C_LESS, C_GT, C_LPAREN, C_RPAREN};
	endfunction

	// General-mode handling: starts a new token or word from byte c, or skips a blank.
	function automatic gen_res_t gen_step(input logic [7:0] c);
		gen_res_t g;
		g.mode  = M_GEN;
		g.wne   = 1'b0;
		g.tok_v = 1'b0;
		g.tok   = '0;
		case (c) inside
			C_NUL: begin
				g.tok_v    = 1'b1;
				g.tok.kind = K_END;
			end
			C_SPACE, C_TAB, C_CR, C_LF: begin
				g.mode = M_GEN;
			end
			C_AMP:    g.mode = M_AMP;
			C_BAR:    g.mode = M_BAR;
			C_SEMI:   g.mode = M_SEMI;
			C_LESS:   g.mode = M_LESS;
			C_GT:     g.mode = M_GT;
			C_HASH:   g.mode = M_COMMENT;
			C_SQUOTE: g.mode = M_SQ;
			C_DQUOTE: g.mode = M_DQ;
			C_BSLASH: g.mode = M_ESCW;
			C_LPAREN: begin
				g.tok_v    = 1'b1;
				g.tok.kind = K_LPAREN;
			end
			C_RPAREN: begin
				g.tok_v    = 1'b1;
				g.tok.kind = K_RPAREN;
			end
			default: begin
				g.tok_v    = 1'b1;
				g.tok.kind = K_CHAR;
				g.tok.ch   = c;
				g.wne      = 1'b1;
				g.mode     = M_WORD;
			end
		endcase
		return g;
	endfunction

	// One lexer step. At most one token comes before the general-mode part
	// (a word end or a pending operator) and at most one comes after it.
	function automatic step_res_t lex_step(input logic [3:0] mode, input logic wne,
		input logic [7:0] c);
		step_res_t r;
		gen_res_t  g;
		logic      pre_v;
		tok_t      pre;
		logic      post_v;
		tok_t      post;
		logic      use_gen;
		g       = gen_step(c);
		pre_v   = 1'b0;
		pre     = '0;
		post_v  = 1'b0;
		post    = '0;
		use_gen = 1'b0;
		r.mode  = mode;
		r.wne   = wne;

		case (mode)
			M_WORD: begin
				if (is_delim(c)) begin
					pre_v    = wne;
					pre.kind = K_WEND;
					use_gen  = 1'b1;
				end else if (c == C_SQUOTE) begin
					r.mode = M_SQ;
				end else if (c == C_DQUOTE) begin
					r.mode = M_DQ;
				end else if (c == C_BSLASH) begin
					r.mode = M_ESCW;
				end else begin
					post_v    = 1'b1;
					post.kind = K_CHAR;
					post.ch   = c;
					r.wne     = 1'b1;
				end
			end
			M_SQ, M_DQ, M_ESCW, M_ESCQ: begin
				if (c == C_NUL) begin
					// End of input inside a quote or escape closes the word.
					pre_v     = wne;
					pre.kind  = K_WEND;
					post_v    = 1'b1;
					post.kind = K_END;
					r.mode    = M_GEN;
					r.wne     = 1'b0;
				end else if (mode == M_SQ && c == C_SQUOTE) begin
					r.mode = M_WORD;
				end else if (mode == M_DQ && c == C_DQUOTE) begin
					r.mode = M_WORD;
				end else if (mode == M_DQ && c == C_BSLASH) begin
					r.mode = M_ESCQ;
				end else begin
					post_v    = 1'b1;
					post.kind = K_CHAR;
					post.ch   = c;
					r.wne     = 1'b1;
					if (mode == M_ESCQ) begin
						r.mode = M_DQ;
					end else if (mode == M_ESCW) begin
						r.mode = M_WORD;
					end
				end
			end
			M_AMP: begin
				if (c == C_AMP) begin
					post_v    = 1'b1;
					post.kind = K_AND;
					r.mode    = M_GEN;
				end else begin
					pre_v    = 1'b1;
					pre.kind = K_AMP;
					use_gen  = 1'b1;
				end
			end
			M_BAR: begin
				if (c == C_BAR) begin
					post_v    = 1'b1;
					post.kind = K_OR;
					r.mode    = M_GEN;
				end else begin
					pre_v    = 1'b1;
					pre.kind = K_PIPE;
					use_gen  = 1'b1;
				end
			end
			M_GT: begin
				if (c == C_GT) begin
					post_v    = 1'b1;
					post.kind = K_APPEND;
					r.mode    = M_GEN;
				end else begin
					pre_v    = 1'b1;
					pre.kind = K_GREATER;
					use_gen  = 1'b1;
				end
			end
			M_SEMI: begin
				pre_v    = 1'b1;
				pre.kind = K_SEMI;
				if (c == C_SEMI) begin
					r.mode = M_GEN;
				end else begin
					use_gen = 1'b1;
				end
			end
			M_LESS: begin
				pre_v    = 1'b1;
				pre.kind = K_LESS;
				if (c == C_LESS) begin
					r.mode = M_GEN;
				end else begin
					use_gen = 1'b1;
				end
			end
			M_COMMENT: begin
				if (c == C_NUL) begin
					post_v    = 1'b1;
					post.kind = K_END;
					r.mode    = M_GEN;
				end else if (c == C_LF) begin
					r.mode = M_GEN;
				end
			end
			default: begin
				use_gen = 1'b1;
			end
		endcase

		if (use_gen) begin
			r.mode = g.mode;
			r.wne  = g.wne;
			post_v = g.tok_v;
			post   = g.tok;
		end

		// Pack the tokens in emission order.
		if (pre_v) begin
			r.r0  = pre;
			r.r1  = post;
			r.cnt = post_v ? 2'd2 : 2'd1;
		end else begin
			r.r0  = post;
			r.r1  = '0;
			r.cnt = post_v ? 2'd1 : 2'd0;
		end
		return r;
	endfunction

endpackage

/* rtl/shell_command_tokenizer.sv */
// Shell command tokenizer: one input byte per transfer, up to two tokens out.
// The input byte is registered, then its tokens go to the result buffer.
// Throughput: one byte per cycle while each byte yields at most one token and
// out_ready holds; a byte that yields two tokens holds the result buffer until
// both are taken. Reset clears the lexer to general mode with an empty word
// and drops all pending bytes and results. Depends on sct_pkg.
`timescale 1ns / 1ps

module shell_command_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] token_kind,
	output logic [7:0] char_out,
	output logic       last_of_run
);

	logic               vld_s1;
	logic [7:0]         char_s1;
	logic [3:0]         mode_q;
	logic               wne_q;
	logic [1:0]         cnt_q;
	sct_pkg::tok_t      r0_q;
	sct_pkg::tok_t      r1_q;
	sct_pkg::step_res_t step;
	logic               out_xfer;
	logic               buf_free;
	logic               advance;

	// Handshake control: the result buffer takes a new byte's tokens once it
	// is empty or is handing over its last token in this cycle.
	assign out_xfer = out_valid && out_ready;
	assign buf_free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);
	assign advance  = vld_s1 && buf_free;
	assign in_ready = !vld_s1 || advance;

	// Lexer step on the registered byte.
	assign step = sct_pkg::lex_step(mode_q, wne_q, char_s1);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
		end
	end

	// Lexer state and result count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sct_pkg::M_GEN;
			wne_q  <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (advance) begin
				mode_q <= step.mode;
				wne_q  <= step.wne;
				cnt_q  <= step.cnt;
			end else if (out_xfer) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Result buffer: the front token is shown, the second moves up after a transfer.
	always_ff @(posedge clk) begin
		if (advance) begin
			r0_q <= step.r0;
			r1_q <= step.r1;
		end else if (out_xfer) begin
			r0_q <= r1_q;
		end
	end

	// The front token is the last of its byte when it is the only one left.
	assign out_valid   = (cnt_q != 2'd0);
	assign token_kind  = r0_q.kind;
	assign char_out    = r0_q.ch;
	assign last_of_run = (cnt_q == 2'd1);

endmodule
